[rtl/r6bam_pkg.sv]
// Package: shared constants, widths and register codes of the RAID6 address mapper.
`timescale 1ns / 1ps
`default_nettype none
package r6bam_pkg;

  // Array size limit default
  localparam int MAX_DISKS_DEF = 64;

  // Field widths
  localparam int ROW_W   = 32;
  localparam int IDX_W   = 6;
  localparam int LSEC_W  = 32;
  localparam int DEV_W   = 6;
  localparam int SEC_W   = 56;
  localparam int DCNT_W  = 7;
  localparam int CHUNK_W = 17;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Quotient bits resolved per divider stage
  localparam int DIV_BPS = 4;

  // Smallest usable disk count
  localparam int MIN_DISKS = 4;

  // Syndrome blocks per stripe and gap codes
  localparam logic [1:0] SYN_CNT  = 2'd2;
  localparam logic [1:0] GAP_NONE = 2'd0;
  localparam logic [1:0] GAP_ONE  = 2'd1;
  localparam logic [1:0] GAP_FULL = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DCNT_W-1:0]  DISK_COUNT_RST = 7'd4;
  localparam logic [CHUNK_W-1:0] CHUNK_RST      = 17'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK_COUNT    = 2'd0,
    REG_CHUNK_SECTORS = 2'd1,
    REG_SEQ_MODE      = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

[rtl/r6bam_in_if.sv]
// Interface: request channel carrying one logical RAID6 request word.
`timescale 1ns / 1ps
`default_nettype none
interface r6bam_in_if;
  logic                         valid;
  logic                         ready;
  logic [r6bam_pkg::ROW_W-1:0]  stripe_row;
  logic [r6bam_pkg::IDX_W-1:0]  data_index;
  logic [r6bam_pkg::LSEC_W-1:0] logical_sector;

  modport source (output valid, stripe_row, data_index, logical_sector, input ready);
  modport sink   (input valid, stripe_row, data_index, logical_sector, output ready);
endinterface
`default_nettype wire

[rtl/r6bam_out_if.sv]
// Interface: result channel carrying one physical mapping word.
`timescale 1ns / 1ps
`default_nettype none
interface r6bam_out_if;
  logic                        valid;
  logic                        ready;
  logic [r6bam_pkg::DEV_W-1:0] data_device;
  logic [r6bam_pkg::SEC_W-1:0] data_sector;
  logic [r6bam_pkg::DEV_W-1:0] first_parity_device;
  logic [r6bam_pkg::DEV_W-1:0] second_parity_device;
  logic [r6bam_pkg::SEC_W-1:0] parity_sector;
  logic                        last_in_stripe;

  modport source (output valid, data_device, data_sector, first_parity_device,
                  second_parity_device, parity_sector, last_in_stripe, input ready);
  modport sink   (input valid, data_device, data_sector, first_parity_device,
                  second_parity_device, parity_sector, last_in_stripe, output ready);
endinterface
`default_nettype wire

[rtl/r6bam_cfg_if.sv]
// Interface: configuration write channel (register index and data).
`timescale 1ns / 1ps
`default_nettype none
interface r6bam_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [r6bam_pkg::CFG_IDX_W-1:0]  index;
  logic [r6bam_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/r6bam_div.sv]
// Pipelined restoring divider with a sideband that travels alongside the word.
`timescale 1ns / 1ps
`default_nettype none
module r6bam_div #(
  parameter int DVD_W  = 32,
  parameter int DSR_W  = 17,
  parameter int BPS    = r6bam_pkg::DIV_BPS,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DSR_W-1:0]  divisor,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [DVD_W-1:0]       quotient,
  output logic [DSR_W-1:0]       remainder,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int STAGES = (DVD_W + BPS - 1) / BPS;

  logic [DVD_W-1:0]  x_r    [STAGES];
  logic [DSR_W-1:0]  rem_r  [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];
  logic              v_r    [STAGES];
  logic [DVD_W-1:0]  x_nxt  [STAGES];
  logic [DSR_W-1:0]  rem_nxt[STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DVD_W-1:0]  x_in;
    logic [DSR_W-1:0]  rem_in;
    logic [SIDE_W-1:0] side_in_s;
    logic              v_in;

    if (s == 0) begin : g_first
      assign x_in      = dividend;
      assign rem_in    = '0;
      assign side_in_s = side_in;
      assign v_in      = in_valid;
    end else begin : g_next
      assign x_in      = x_r[s-1];
      assign rem_in    = rem_r[s-1];
      assign side_in_s = side_r[s-1];
      assign v_in      = v_r[s-1];
    end

    // Resolve BPS quotient bits: shift in a dividend bit, subtract when it fits
    always_comb begin
      logic [DVD_W-1:0] x;
      logic [DSR_W-1:0] r;
      logic [DSR_W:0]   t;
      x = x_in;
      r = rem_in;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < DVD_W) begin
          t = {r, x[DVD_W-1]};
          if (t >= {1'b0, divisor}) begin
            r = DSR_W'(t - {1'b0, divisor});
            x = {x[DVD_W-2:0], 1'b1};
          end else begin
            r = t[DSR_W-1:0];
            x = {x[DVD_W-2:0], 1'b0};
          end
        end
      end
      x_nxt[s]   = x;
      rem_nxt[s] = r;
    end

    // Advance valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    // Advance payload
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]    <= x_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        side_r[s] <= side_in_s;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign quotient  = x_r[STAGES-1];
  assign remainder = rem_r[STAGES-1];
  assign side_out  = side_r[STAGES-1];

endmodule
`default_nettype wire

[rtl/raid6_block_address_mapper_top.sv]
// Top level: RAID6 rotating-parity block address mapper pipeline.
//
// Channels: in_ch takes one request word (stripe_row, data_index,
// logical_sector); out_ch returns one mapping word per request, in order
// (data disk and sector, both syndrome disks, shared parity sector, and
// the last-block flag when sequential mode is on). cfg_ch writes the
// disk_count, chunk_sectors and sequential_mode registers; it is always
// ready. The user must write it only while no request is in flight; the
// block does not enforce this. Throughput: one request per cycle while
// out_ch does not stall. The pipeline runs through the offset divider,
// stage A, the lane and row dividers, stage B, the slot divider, stage C
// and the output register D; the four chained restoring dividers resolve
// four quotient bits per stage.
// Reset clears all valid bits and loads disk_count = 4, chunk_sectors = 8,
// sequential_mode = 0. When out_ch stalls, the whole pipeline holds and
// in_ch.ready drops; no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module raid6_block_address_mapper_top #(
  parameter int MAX_DISKS = r6bam_pkg::MAX_DISKS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  r6bam_in_if.sink    in_ch,
  r6bam_out_if.source out_ch,
  r6bam_cfg_if.sink   cfg_ch
);

  localparam int NW    = $clog2(MAX_DISKS + 1);
  localparam int CW    = (NW > r6bam_pkg::DCNT_W) ? NW : r6bam_pkg::DCNT_W;
  localparam int DB_W  = r6bam_pkg::ROW_W + NW + 1;
  localparam int SL_W  = DB_W + 2;
  localparam int CK_W  = r6bam_pkg::CHUNK_W;
  localparam int PR_W  = SL_W + CK_W;
  localparam int LSIDE = r6bam_pkg::ROW_W + r6bam_pkg::IDX_W;
  localparam int S1_W  = DB_W + CK_W;
  localparam int S2_W  = DB_W + DB_W + NW + CK_W;
  localparam int S3_W  = 2 + NW + NW + CK_W;

  // Configuration registers
  logic [r6bam_pkg::DCNT_W-1:0] disk_count_r;
  logic [CK_W-1:0]              chunk_r;
  logic                         seq_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_count_r <= r6bam_pkg::DISK_COUNT_RST;
      chunk_r      <= r6bam_pkg::CHUNK_RST;
      seq_mode_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (r6bam_pkg::reg_idx_t'(cfg_ch.index))
        r6bam_pkg::REG_DISK_COUNT:    disk_count_r <= cfg_ch.data[r6bam_pkg::DCNT_W-1:0];
        r6bam_pkg::REG_CHUNK_SECTORS: chunk_r      <= cfg_ch.data[CK_W-1:0];
        r6bam_pkg::REG_SEQ_MODE:      seq_mode_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Clamp disk count and chunk size to usable values
  logic [NW-1:0]   n_eff;
  logic [CK_W-1:0] chunk_eff;
  logic [CW-1:0]   dc_ext;

  always_comb begin
    dc_ext = CW'(disk_count_r);
    if (dc_ext < CW'(r6bam_pkg::MIN_DISKS)) begin
      n_eff = NW'(r6bam_pkg::MIN_DISKS);
    end else if (dc_ext > CW'(MAX_DISKS)) begin
      n_eff = NW'(MAX_DISKS);
    end else begin
      n_eff = NW'(dc_ext);
    end
    chunk_eff = (chunk_r == '0) ? CK_W'(1) : chunk_r;
  end

  // Global advance: hold everything while the output word waits
  logic en;
  logic d_v_r;
  assign en          = !d_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // Offset within chunk
  logic                         l_v;
  logic [LSIDE-1:0]             l_side;
  logic [CK_W-1:0]              l_off;
  logic [r6bam_pkg::ROW_W-1:0]  l_row;
  logic [r6bam_pkg::IDX_W-1:0]  l_idx;

  r6bam_div #(
    .DVD_W (r6bam_pkg::LSEC_W),
    .DSR_W (CK_W),
    .BPS   (r6bam_pkg::DIV_BPS),
    .SIDE_W(LSIDE)
  ) u_div_off (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .dividend (in_ch.logical_sector),
    .divisor  (chunk_eff),
    .side_in  ({in_ch.stripe_row, in_ch.data_index}),
    .out_valid(l_v),
    .quotient (),
    .remainder(l_off),
    .side_out (l_side)
  );

  assign {l_row, l_idx} = l_side;

  // Stage A: linear data block number
  logic            a_v_r;
  logic [DB_W-1:0] a_dblk_r, a_dblk_nxt;
  logic [CK_W-1:0] a_off_r;

  assign a_dblk_nxt = DB_W'((r6bam_pkg::ROW_W + NW)'(l_row) * (r6bam_pkg::ROW_W + NW)'(n_eff))
                    + DB_W'(l_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dblk_r <= a_dblk_nxt;
      a_off_r  <= l_off;
    end
  end

  // Lane and position: block number over data disks per row
  logic            q1_v;
  logic [DB_W-1:0] q1_lane;
  logic [NW-1:0]   q1_pos;
  logic [S1_W-1:0] q1_side;
  logic [DB_W-1:0] q1_dblk;
  logic [CK_W-1:0] q1_off;

  r6bam_div #(
    .DVD_W (DB_W),
    .DSR_W (NW),
    .BPS   (r6bam_pkg::DIV_BPS),
    .SIDE_W(S1_W)
  ) u_div_lane (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (a_v_r),
    .dividend (a_dblk_r),
    .divisor  (n_eff - NW'(r6bam_pkg::SYN_CNT)),
    .side_in  ({a_dblk_r, a_off_r}),
    .out_valid(q1_v),
    .quotient (q1_lane),
    .remainder(q1_pos),
    .side_out (q1_side)
  );

  assign {q1_dblk, q1_off} = q1_side;

  // Row inside the square: lane modulo disk count
  logic            q2_v;
  logic [NW-1:0]   q2_y;
  logic [S2_W-1:0] q2_side;
  logic [DB_W-1:0] q2_dblk, q2_lane;
  logic [NW-1:0]   q2_pos;
  logic [CK_W-1:0] q2_off;

  r6bam_div #(
    .DVD_W (DB_W),
    .DSR_W (NW),
    .BPS   (r6bam_pkg::DIV_BPS),
    .SIDE_W(S2_W)
  ) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q1_v),
    .dividend (q1_lane),
    .divisor  (n_eff),
    .side_in  ({q1_dblk, q1_lane, q1_pos, q1_off}),
    .out_valid(q2_v),
    .quotient (),
    .remainder(q2_y),
    .side_out (q2_side)
  );

  assign {q2_dblk, q2_lane, q2_pos, q2_off} = q2_side;

  // Stage B: gap rule, physical slot and syndrome disks
  logic            b_v_r;
  logic [1:0]      b_gap_r, b_gap_nxt;
  logic [SL_W-1:0] b_slot_r, b_slot_nxt;
  logic [NW-1:0]   b_p0_r, b_p0_nxt, b_p1_r, b_p1_nxt;
  logic [CK_W-1:0] b_off_r;

  always_comb begin
    b_gap_nxt = r6bam_pkg::GAP_FULL;
    if (q2_y == n_eff - NW'(1)) begin
      b_gap_nxt = r6bam_pkg::GAP_ONE;
    end
    if ((NW + 1)'(q2_pos) + (NW + 1)'(q2_y) < (NW + 1)'(n_eff - NW'(r6bam_pkg::SYN_CNT))) begin
      b_gap_nxt = r6bam_pkg::GAP_NONE;
    end
    b_slot_nxt = SL_W'(q2_dblk) + SL_W'(b_gap_nxt) + {1'b0, q2_lane, 1'b0};
    b_p1_nxt   = n_eff - NW'(1) - q2_y;
    b_p0_nxt   = (q2_y < n_eff - NW'(1)) ? b_p1_nxt - NW'(1) : n_eff - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= q2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_gap_r  <= b_gap_nxt;
      b_slot_r <= b_slot_nxt;
      b_p0_r   <= b_p0_nxt;
      b_p1_r   <= b_p1_nxt;
      b_off_r  <= q2_off;
    end
  end

  // Disk and chunk row of the slot
  logic            q3_v;
  logic [SL_W-1:0] q3_crow;
  logic [NW-1:0]   q3_dev;
  logic [S3_W-1:0] q3_side;
  logic [1:0]      q3_gap;
  logic [NW-1:0]   q3_p0, q3_p1;
  logic [CK_W-1:0] q3_off;

  r6bam_div #(
    .DVD_W (SL_W),
    .DSR_W (NW),
    .BPS   (r6bam_pkg::DIV_BPS),
    .SIDE_W(S3_W)
  ) u_div_slot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_v_r),
    .dividend (b_slot_r),
    .divisor  (n_eff),
    .side_in  ({b_gap_r, b_p0_r, b_p1_r, b_off_r}),
    .out_valid(q3_v),
    .quotient (q3_crow),
    .remainder(q3_dev),
    .side_out (q3_side)
  );

  assign {q3_gap, q3_p0, q3_p1, q3_off} = q3_side;

  // Stage C: chunk start sector and last-block flag
  logic                        c_v_r;
  logic [r6bam_pkg::SEC_W-1:0] c_start_r;
  logic [PR_W-1:0]             c_prod;
  logic                        c_last_r, c_last_nxt;
  logic [NW-1:0]               c_dev_r, c_p0_r, c_p1_r;
  logic [CK_W-1:0]             c_off_r;

  assign c_prod     = PR_W'(q3_crow) * PR_W'(chunk_eff);
  assign c_last_nxt = seq_mode_r &&
                      ((NW + 1)'(q3_dev) + (NW + 1)'(r6bam_pkg::SYN_CNT - q3_gap)
                       == (NW + 1)'(n_eff - NW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= q3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_start_r <= r6bam_pkg::SEC_W'(c_prod);
      c_last_r  <= c_last_nxt;
      c_dev_r   <= q3_dev;
      c_p0_r    <= q3_p0;
      c_p1_r    <= q3_p1;
      c_off_r   <= q3_off;
    end
  end

  // Stage D: output word register
  logic [r6bam_pkg::DEV_W-1:0] d_dev_r, d_p0_r, d_p1_r;
  logic [r6bam_pkg::SEC_W-1:0] d_dsec_r, d_psec_r;
  logic                        d_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_dev_r  <= r6bam_pkg::DEV_W'(c_dev_r);
      d_p0_r   <= r6bam_pkg::DEV_W'(c_p0_r);
      d_p1_r   <= r6bam_pkg::DEV_W'(c_p1_r);
      d_dsec_r <= c_start_r + r6bam_pkg::SEC_W'(c_off_r);
      d_psec_r <= c_start_r;
      d_last_r <= c_last_r;
    end
  end

  assign out_ch.valid                = d_v_r;
  assign out_ch.data_device          = d_dev_r;
  assign out_ch.data_sector          = d_dsec_r;
  assign out_ch.first_parity_device  = d_p0_r;
  assign out_ch.second_parity_device = d_p1_r;
  assign out_ch.parity_sector        = d_psec_r;
  assign out_ch.last_in_stripe       = d_last_r;

endmodule
`default_nettype wire

[rtl/r6bam_chk.sv]
// Checker: port-level assertions for the RAID6 address mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module r6bam_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [r6bam_pkg::DEV_W-1:0] out_dev,
  input wire logic [r6bam_pkg::SEC_W-1:0] out_dsec
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // Keep a stalled word's payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_dev) && $stable(out_dsec))
    else $error("output payload changed while stalled");

  // Take input exactly when the pipeline can advance
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow pipeline advance");

  // Come out of reset empty
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind raid6_block_address_mapper_top r6bam_chk u_r6bam_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_dev  (out_ch.data_device),
  .out_dsec (out_ch.data_sector)
);
`default_nettype wire
